// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the empirical CDF p-value block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/ecdf_pkg.sv
// Types and constants shared by the empirical CDF p-value block.
`timescale 1ns / 1ps
package ecdf_pkg;

	localparam int NULL_DEPTH = 1024;
	localparam int NULL_AW    = $clog2(NULL_DEPTH);
	localparam int CNT_W      = $clog2(NULL_DEPTH + 1);
	localparam int REM_W      = CNT_W + 1;
	localparam int SAMPLE_W   = 32;
	localparam int P_W        = 17;
	localparam int DIV_STEPS  = P_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                       op;
		logic [9:0]                 null_index;
		logic signed [SAMPLE_W-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [P_W-1:0]   p_value;
		logic [CNT_W-1:0] le_count;
	} out_item_t;

	typedef struct packed {
		logic                       is_query;
		logic [NULL_AW-1:0]         index;
		logic signed [SAMPLE_W-1:0] sample;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_DONE
	} ecdf_state_t;

endpackage

// File: rtl/empirical_cdf_two_sided_pvalue.sv
// Top level of the empirical CDF two-sided p-value block.
`timescale 1ns / 1ps
// The input side behaves as a queue: an item is taken on a clock edge with push high and full
// low. A load item (op clear) writes sample_value to entry null_index of the null store and
// gives no result. A query item (op set) counts the first N stored entries that are at or
// below its sample, using a signed compare, and returns that count with the p-value
// 2*min(c, N-c)/N in unsigned Q1.16, truncated.
// The result side also behaves as a queue: the oldest result is shown while empty is low
// and is taken on an edge with pop high.
// N is set through cfg_we and cfg_data; the user must write it only while the block is
// idle, as the block does not enforce this. Zero acts as one, values above the store depth
// act as the depth, and reset sets N to the store depth. A load passes through the queue
// and is written to the store when the back end takes it. For a query, the back end reads
// the first N store entries one entry a cycle, drains the registered read, divides with a
// restoring divider giving one quotient bit a cycle and loads the result, taking no new item
// until that result is loaded. A two-item queue sits between the front and back ends and a
// result register holds the finished item; the back end waits only when a new result is
// ready and the last one is not taken, and input stops once the queue is full behind it.
// Reset clears all control state; the store contents stay undefined until loaded.
module empirical_cdf_two_sided_pvalue import ecdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  in_item_t         in_item,
	output logic             empty,
	input  logic             pop,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	ecdf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	ecdf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

// File: rtl/ecdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module ecdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/ecdf_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module ecdf_front import ecdf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_item,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	cmd_t               cmdq_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0] wr_ptr_q;
	logic [CMDQ_PW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;
	cmd_t               new_cmd;

	assign full      = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = cmdq_q[rd_ptr_q];

	always_comb begin
		new_cmd.is_query = (in_item.op == OP_QUERY);
		new_cmd.index    = in_item.null_index[NULL_AW-1:0];
		new_cmd.sample   = in_item.sample_value;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmdq_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/ecdf_back.sv
// Back end: writes the null store, counts entries at or below a query and divides.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ecdf_back import ecdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output out_item_t        out_item
);

	ecdf_state_t                state_q;
	ecdf_state_t                state_d;
	logic [CNT_W-1:0]           n_eff_q;
	logic [CNT_W-1:0]           issue_q;
	logic [CNT_W-1:0]           le_cnt_q;
	logic                       rd_vld_s1;
	logic signed [SAMPLE_W-1:0] key_q;
	logic [REM_W-1:0]           rem_q;
	logic [P_W-1:0]             quo_q;
	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	out_item_t                  out_q;
	logic                       ram_we;
	logic                       ram_re;
	logic                       out_load;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic [CNT_W-1:0]           upper_cnt;
	logic [REM_W-1:0]           rem_dbl;
	logic                       rem_ge;

	ecdf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(NULL_DEPTH)
	) u_null_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd.index),
		.wdata(cmd.sample),
		.re   (ram_re),
		.raddr(issue_q[NULL_AW-1:0]),
		.rdata(ram_rdata)
	);

	assign upper_cnt = n_eff_q - le_cnt_q;
	assign rem_dbl   = {rem_q[REM_W-2:0], 1'b0};
	assign rem_ge    = (rem_dbl >= {1'b0, n_eff_q});
	assign empty     = !out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.is_query) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if ((issue_q == n_eff_q) && !rd_vld_s1) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || pop) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_pop = cmd_valid;
				ram_we  = cmd_valid && !cmd.is_query;
			end
			ST_WALK: begin
				ram_re = (issue_q != n_eff_q);
			end
			ST_DIV: begin
			end
			ST_DONE: begin
				out_load = !out_valid_q || pop;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_eff_q     <= CNT_W'(NULL_DEPTH);
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			if (cfg_we) begin
				if (cfg_data == '0) begin
					n_eff_q <= CNT_W'(1);
				end else if (cfg_data > CNT_W'(NULL_DEPTH)) begin
					n_eff_q <= CNT_W'(NULL_DEPTH);
				end else begin
					n_eff_q <= cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.is_query) begin
			key_q    <= cmd.sample;
			issue_q  <= '0;
			le_cnt_q <= '0;
		end
		if (ram_re) begin
			issue_q <= issue_q + 1'b1;
		end
		if (rd_vld_s1 && ($signed(ram_rdata) <= key_q)) begin
			le_cnt_q <= le_cnt_q + 1'b1;
		end
		if ((state_q == ST_WALK) && (state_d == ST_DIV)) begin
			rem_q  <= (le_cnt_q < upper_cnt) ? {1'b0, le_cnt_q} : {1'b0, upper_cnt};
			step_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q  <= rem_ge ? (rem_dbl - {1'b0, n_eff_q}) : rem_dbl;
			quo_q  <= {quo_q[P_W-2:0], rem_ge};
			step_q <= step_q + 1'b1;
		end
		if (out_load) begin
			out_q.p_value  <= quo_q;
			out_q.le_count <= le_cnt_q;
		end
	end

	`ASSERT_NEVER(a_count_bound, clk, arst_n, le_cnt_q > n_eff_q && state_q != ST_IDLE, "count above N")
	`ASSERT_NEVER(a_issue_bound, clk, arst_n, state_q == ST_WALK && issue_q > n_eff_q, "walk past N")
	`ASSERT_IMPLY(a_rem_bound, clk, arst_n, state_q == ST_DIV |-> rem_q < REM_W'(n_eff_q), "remainder not below N")
	`ASSERT_IMPLY(a_p_bound, clk, arst_n, out_valid_q |-> out_q.p_value <= P_W'(65536), "p-value above one")

endmodule
